FILE: design/dtm_pkg.sv
package dtm_pkg;

    typedef enum logic [2:0] {
        CFG_CODE_A       = 3'd0,
        CFG_CODE_B       = 3'd1,
        CFG_SYMBOL_LIMIT = 3'd2,
        CFG_CARRIER_STEP = 3'd3,
        CFG_AMPLITUDE    = 3'd4
    } t_cfg_index;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [7:0]  CODE_A_RESET       = 8'd0;
    localparam logic [7:0]  CODE_B_RESET       = 8'd0;
    localparam logic [15:0] SYMBOL_LIMIT_RESET = 16'd127;
    localparam logic [31:0] CARRIER_STEP_RESET = 32'h2000_0000;
    localparam logic [14:0] AMPLITUDE_RESET    = 15'd16384;

    localparam logic [3:0] BITS_PER_CODE = 4'd8;
    localparam int         CODE_MSB      = 7;

    localparam int SAMPLE_FIELD_WIDTH = 16;
    localparam int AMPLITUDE_WIDTH    = 15;

    typedef struct packed {
        logic [15:0] duty_counter;
        logic [3:0]  bits_left;
        logic [7:0]  shift_a;
        logic [7:0]  shift_b;
        logic [1:0]  diff_phase;
    } t_ctl_state;

    localparam longint unsigned SINE_COEF [7] = '{
        64'd1686629713, 64'd693598668, 64'd85569302, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };

    // gray mapped phase advance in quarter turns
    function automatic logic [1:0] gray_step(input logic [1:0] dibit);
        logic [1:0] step;
        case (dibit)
            2'd0:    step = 2'd0;
            2'd1:    step = 2'd1;
            2'd2:    step = 2'd3;
            default: step = 2'd2;
        endcase
        return step;
    endfunction

    // quarter wave entry k of 2^(tb-2), scaled to 2^(sw-1)-1, evaluated at elaboration
    function automatic longint unsigned sine_entry(input longint unsigned k, input int tb,
                                                   input int sw);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned p;
        longint unsigned m;
        longint unsigned t;
        u  = k << (32 - tb);
        u2 = (u * u) >> 30;
        p  = SINE_COEF[6];
        for (int i = 5; i >= 0; i--) begin
            p = SINE_COEF[i] - ((p * u2) >> 30);
        end
        p = (u * p) >> 30;
        if (p > (64'd1 << 30)) begin
            p = 64'd1 << 30;
        end
        m = (64'd1 << (sw - 1)) - 64'd1;
        t = (p * m + (64'd1 << 29)) >> 30;
        if (t > m) begin
            t = m;
        end
        return t;
    endfunction

endpackage

FILE: design/dtm_tick_if.sv
interface dtm_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

FILE: design/dtm_result_if.sv
interface dtm_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               symbol_start;
    logic [1:0]         phase_quadrant;

    modport source (output valid, output sample, output symbol_start, output phase_quadrant,
                    input ready);
    modport sink (input valid, input sample, input symbol_start, input phase_quadrant,
                  output ready);
endinterface

FILE: design/dqpsk_tone_modulator.sv
// an input transaction passes through stage 1, stage 2, stage 3 and the output register
// throughput: one transaction per cycle while the output is not stalled, set by the
// read-modify-write of the state entry with the last write forwarded
// reset: synchronous, active low; registers return to their defaults and the state
// is reinitialised, so the first tick starts a symbol; no clearing pass
module dqpsk_tone_modulator #(
    parameter int SINE_TABLE_DEPTH  = 1024,
    parameter int SAMPLE_WIDTH      = 16,
    parameter int ACCUMULATOR_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dtm_tick_if.sink                             i_tick,
    dtm_result_if.source                         o_result,
    input  logic                                 i_cfg_we,
    input  logic [dtm_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [dtm_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int AW        = ACCUMULATOR_WIDTH;
    localparam int FLOOR_LOG = $clog2(SINE_TABLE_DEPTH + 1) - 1;
    localparam int TB_CLAMP  = FLOOR_LOG < 6 ? 6 : (FLOOR_LOG > 16 ? 16 : FLOOR_LOG);
    localparam int TB        = TB_CLAMP > AW ? AW : TB_CLAMP;
    localparam int CTL_W     = $bits(dtm_pkg::t_ctl_state);
    localparam int MAG_W     = dtm_pkg::AMPLITUDE_WIDTH + SAMPLE_WIDTH - 1;
    localparam int OUT_W     = dtm_pkg::SAMPLE_FIELD_WIDTH;
    localparam logic [TB-2:0] QUARTER = (TB - 1)'(1) << (TB - 2);
    localparam logic [MAG_W:0] ROUND_UP = (MAG_W + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);

    // configuration registers
    logic [7:0]  r_code_a;
    logic [7:0]  r_code_b;
    logic [15:0] r_limit;
    logic [31:0] r_carrier_step;
    logic [14:0] r_amplitude;
    logic        r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_a       <= dtm_pkg::CODE_A_RESET;
            r_code_b       <= dtm_pkg::CODE_B_RESET;
            r_limit        <= dtm_pkg::SYMBOL_LIMIT_RESET;
            r_carrier_step <= dtm_pkg::CARRIER_STEP_RESET;
            r_amplitude    <= dtm_pkg::AMPLITUDE_RESET;
            r_init         <= 1'b1;
        end else if (i_cfg_we) begin
            case (dtm_pkg::t_cfg_index'(i_cfg_index))
                dtm_pkg::CFG_CODE_A: begin
                    r_code_a <= i_cfg_data[7:0];
                    r_init   <= 1'b1;
                end
                dtm_pkg::CFG_CODE_B: begin
                    r_code_b <= i_cfg_data[7:0];
                    r_init   <= 1'b1;
                end
                dtm_pkg::CFG_SYMBOL_LIMIT: begin
                    r_limit <= i_cfg_data[15:0];
                    r_init  <= 1'b1;
                end
                dtm_pkg::CFG_CARRIER_STEP: begin
                    r_carrier_step <= i_cfg_data;
                    r_init         <= 1'b1;
                end
                dtm_pkg::CFG_AMPLITUDE: begin
                    r_amplitude <= i_cfg_data[14:0];
                    r_init      <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_tick.valid && i_tick.ready) begin
            r_init <= 1'b0;
        end
    end

    // pipeline enables
    logic w_accept;
    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_en_out;
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;

    assign w_en_out = !r_out_valid || o_result.ready;
    assign w_en3    = !r_s3_valid || w_en_out;
    assign w_en2    = !r_s2_valid || w_en3;
    assign w_en1    = !r_s1_valid || w_en2;
    assign i_tick.ready = w_en1;
    assign w_accept = i_tick.valid && w_en1;

    // state entry, read every cycle, written on each transaction
    logic [AW+CTL_W-1:0]     w_ram_rdata;
    logic [AW+CTL_W-1:0]     w_ram_wdata;
    logic                    r_fwd_hit;
    dtm_pkg::t_ctl_state     r_fwd_ctl;
    logic [AW-1:0]           r_fwd_acc;
    dtm_pkg::t_ctl_state     w_reinit;
    dtm_pkg::t_ctl_state     w_cur_ctl;
    logic [AW-1:0]           w_cur_acc;
    dtm_pkg::t_ctl_state     n_ctl;
    logic [AW-1:0]           n_acc;
    logic                    w_start;
    logic [1:0]              w_dibit;
    logic [AW-1:0]           w_phase;
    logic [TB-1:0]           w_idx;
    logic [1:0]              w_quad;
    logic [TB-2:0]           w_k;

    dtm_ram #(
        .WIDTH (AW + CTL_W),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (1'b0),
        .i_wdata (w_ram_wdata),
        .i_raddr (1'b0),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        w_reinit.duty_counter = r_limit;
        w_reinit.bits_left    = dtm_pkg::BITS_PER_CODE;
        w_reinit.shift_a      = r_code_a;
        w_reinit.shift_b      = r_code_b;
        w_reinit.diff_phase   = 2'd0;
    end

    always_comb begin
        if (r_init || i_tick.restart) begin
            w_cur_ctl = w_reinit;
            w_cur_acc = '0;
        end else if (r_fwd_hit) begin
            w_cur_ctl = r_fwd_ctl;
            w_cur_acc = r_fwd_acc;
        end else begin
            w_cur_ctl = dtm_pkg::t_ctl_state'(w_ram_rdata[CTL_W-1:0]);
            w_cur_acc = w_ram_rdata[AW+CTL_W-1:CTL_W];
        end
    end

    always_comb begin
        n_ctl   = w_cur_ctl;
        w_start = 1'b0;
        w_dibit = 2'd0;
        if (w_cur_ctl.duty_counter < r_limit) begin
            n_ctl.duty_counter = w_cur_ctl.duty_counter + 16'd1;
        end else begin
            w_start            = 1'b1;
            n_ctl.duty_counter = '0;
            if (w_cur_ctl.bits_left == 4'd0) begin
                n_ctl.bits_left = dtm_pkg::BITS_PER_CODE;
                n_ctl.shift_a   = r_code_a;
                n_ctl.shift_b   = r_code_b;
            end
            w_dibit = {n_ctl.shift_a[dtm_pkg::CODE_MSB], n_ctl.shift_b[dtm_pkg::CODE_MSB]};
            n_ctl.diff_phase = n_ctl.diff_phase + dtm_pkg::gray_step(w_dibit);
            n_ctl.shift_a    = {n_ctl.shift_a[dtm_pkg::CODE_MSB-1:0], 1'b0};
            n_ctl.shift_b    = {n_ctl.shift_b[dtm_pkg::CODE_MSB-1:0], 1'b0};
            n_ctl.bits_left  = n_ctl.bits_left - 4'd1;
        end
    end

    assign n_acc       = w_cur_acc + AW'(r_carrier_step);
    assign w_ram_wdata = {n_acc, n_ctl};
    assign w_phase     = w_cur_acc + {n_ctl.diff_phase, {(AW - 2){1'b0}}};
    assign w_idx       = w_phase[AW-1 -: TB];
    assign w_quad      = w_idx[TB-1 -: 2];
    assign w_k         = w_quad[0] ? (QUARTER - {1'b0, w_idx[TB-3:0]})
                                   : {1'b0, w_idx[TB-3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd_ctl <= n_ctl;
            r_fwd_acc <= n_acc;
        end
    end

    // stage 1: table address
    logic [TB-2:0] r_s1_k;
    logic          r_s1_neg;
    logic          r_s1_start;
    logic [1:0]    r_s1_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_k     <= w_k;
            r_s1_neg   <= w_quad[1];
            r_s1_start <= w_start;
            r_s1_phase <= n_ctl.diff_phase;
        end
    end

    // stage 2: table value
    logic [SAMPLE_WIDTH-2:0] w_t;
    logic                    r_s2_neg;
    logic                    r_s2_start;
    logic [1:0]              r_s2_phase;

    dtm_sine_rom #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TABLE_BITS   (TB)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_en    (w_en2),
        .i_index (r_s1_k),
        .o_value (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_neg   <= r_s1_neg;
            r_s2_start <= r_s1_start;
            r_s2_phase <= r_s1_phase;
        end
    end

    // stage 3: amplitude scaling
    logic [MAG_W-1:0] r_s3_mag;
    logic             r_s3_neg;
    logic             r_s3_start;
    logic [1:0]       r_s3_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_mag   <= MAG_W'(r_amplitude) * MAG_W'(w_t);
            r_s3_neg   <= r_s2_neg && (w_t != '0);
            r_s3_start <= r_s2_start;
            r_s3_phase <= r_s2_phase;
        end
    end

    // output register, negative values rounded towards minus infinity
    logic [MAG_W:0]   w_mag_up;
    logic [OUT_W-1:0] w_ceil;
    logic [OUT_W-1:0] n_sample;
    logic [OUT_W-1:0] r_out_sample;
    logic             r_out_start;
    logic [1:0]       r_out_phase;

    assign w_mag_up = {1'b0, r_s3_mag} + ROUND_UP;
    assign w_ceil   = w_mag_up[MAG_W:SAMPLE_WIDTH-1];
    assign n_sample = r_s3_neg ? (OUT_W'(0) - w_ceil)
                               : OUT_W'(r_s3_mag[MAG_W-1:SAMPLE_WIDTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_sample <= n_sample;
            r_out_start  <= r_s3_start;
            r_out_phase  <= r_s3_phase;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.sample         = r_out_sample;
    assign o_result.symbol_start   = r_out_start;
    assign o_result.phase_quadrant = r_out_phase;

    a_restart_starts_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_tick.restart) |-> w_start)
        else $error("restart did not begin a symbol");

    a_ram_matches_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_init && !r_fwd_hit && !i_tick.restart) |-> (w_ram_rdata == {r_fwd_acc, r_fwd_ctl}))
        else $error("state entry differs from last written state");

    a_bits_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_cur_ctl.bits_left <= dtm_pkg::BITS_PER_CODE))
        else $error("bits left out of range");

endmodule

FILE: design/dtm_ram.sv
module dtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/dtm_sine_rom.sv
module dtm_sine_rom #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TABLE_BITS   = 10
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [TABLE_BITS-2:0]   i_index,
    output logic [SAMPLE_WIDTH-2:0] o_value
);

    localparam int ENTRIES = (1 << (TABLE_BITS - 2)) + 1;

    logic [SAMPLE_WIDTH-2:0] w_table [ENTRIES];
    logic [SAMPLE_WIDTH-2:0] r_value;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        assign w_table[k] = (SAMPLE_WIDTH - 1)'(dtm_pkg::sine_entry(k, TABLE_BITS,
                                                                    SAMPLE_WIDTH));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= w_table[i_index];
        end
    end

    assign o_value = r_value;

endmodule
